/* rtl/aifp_pkg.sv */
package aifp_pkg;

  localparam int unsigned CNT_W = 25;

  // Field width that means "no limit"
  localparam logic [CNT_W-1:0] NO_LIMIT_WIDTH = CNT_W'(1 << 24);

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_RADIX_MODE  = 1'b0;
  localparam logic REG_FIELD_WIDTH = 1'b1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  typedef enum logic [1:0] {
    MODE_AUTO = 2'd0,
    MODE_OCT  = 2'd1,
    MODE_DEC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    RAD_NONE = 2'd0,
    RAD_OCT  = 2'd1,
    RAD_DEC  = 2'd2,
    RAD_HEX  = 2'd3
  } radix_t;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    mode_t            radix_mode;
    logic [CNT_W-1:0] field_width;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Digit value of c in radix r; ok is low when c is no digit of r
  function automatic digit_t digit_of(logic [7:0] c, radix_t r);
    digit_t     res;
    logic [5:0] d;
    logic       alnum;
    logic [5:0] lim;
    d     = 6'd0;
    alnum = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d     = 6'(c - CH_ZERO);
      alnum = 1'b1;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d     = 6'(c - CH_LO_A + 8'd10);
      alnum = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d     = 6'(c - CH_UP_A + 8'd10);
      alnum = 1'b1;
    end
    unique case (r)
      RAD_OCT: lim = 6'd8;
      RAD_DEC: lim = 6'd10;
      RAD_HEX: lim = 6'd16;
      default: lim = 6'd0;
    endcase
    res.ok  = alnum && (d < lim);
    res.val = d[3:0];
    return res;
  endfunction

endpackage

/* rtl/ascii_integer_field_parser.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  char_code, field_start
// out_      output     out_valid/out_stall  char_taken, field_done, parse_ok,
//                                           magnitude, is_negative, chars_used
// cfg_      input      APB write/read       radix_mode (0x0), field_width (0x4)
//
// One item per cycle sustained while out_stall stays low.
// Input register, then parse step and field state updated with the result register.
// Reset (rst_n low, synchronous) clears valids, field state and registers.
// out_stall holds the result; in_stall rises only while both stages are full.
module ascii_integer_field_parser #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_field_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_char_taken,
  output logic                          out_field_done,
  output logic                          out_parse_ok,
  output logic [VALUE_BITS-1:0]         out_magnitude,
  output logic                          out_is_negative,
  output logic [aifp_pkg::CNT_W-1:0]    out_chars_used,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [aifp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [aifp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [aifp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import aifp_pkg::*;

  cfg_t       cfg;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_start_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       step;
  logic       in_acc;

  assign out_free      = !out_valid_r || !out_stall;
  assign step          = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_acc        = in_valid && !in_stall;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !step);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r  <= in_char_code;
      s1_start_r <= in_field_start;
    end
  end

  assign out_valid = out_valid_r;

  aifp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  aifp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .char_code   (s1_char_r),
    .field_start (s1_start_r),
    .cfg         (cfg),
    .char_taken  (out_char_taken),
    .field_done  (out_field_done),
    .parse_ok    (out_parse_ok),
    .magnitude   (out_magnitude),
    .is_negative (out_is_negative),
    .chars_used  (out_chars_used)
  );

endmodule

/* rtl/aifp_regs.sv */
module aifp_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [aifp_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [aifp_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [aifp_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready,
  output aifp_pkg::cfg_t                 cfg
);
  import aifp_pkg::*;

  mode_t            mode_r;
  logic [CNT_W-1:0] width_r;
  logic             wr_en;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_AUTO;
      width_r <= NO_LIMIT_WIDTH;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_RADIX_MODE:  mode_r  <= mode_t'(cfg_pwdata[1:0]);
        REG_FIELD_WIDTH: width_r <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_RADIX_MODE:  cfg_prdata = {{(CFG_DW-2){1'b0}}, mode_r};
      REG_FIELD_WIDTH: cfg_prdata = {{(CFG_DW-CNT_W){1'b0}}, width_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.radix_mode  = mode_r;
  assign cfg.field_width = width_r;

endmodule

/* rtl/aifp_core.sv */
module aifp_core #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    char_code,
  input  logic                          field_start,
  input  aifp_pkg::cfg_t                cfg,
  output logic                          char_taken,
  output logic                          field_done,
  output logic                          parse_ok,
  output logic [VALUE_BITS-1:0]         magnitude,
  output logic                          is_negative,
  output logic [aifp_pkg::CNT_W-1:0]    chars_used
);
  import aifp_pkg::*;

  phase_t                phase_r, phase_nxt;
  radix_t                radix_r, radix_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic                  dseen_r, dseen_nxt;
  logic                  taken_r, taken_nxt;
  logic                  done_r, done_nxt;
  logic                  ok_r, ok_nxt;

  always_comb begin
    phase_t                ph;
    phase_t                cur;
    logic [CNT_W-1:0]      limit;
    logic                  idle;
    logic                  dstep;
    digit_t                dg;
    logic [VALUE_BITS-1:0] scaled;
    logic [VALUE_BITS-1:0] dval;

    // field_start clears the field before this character is looked at
    if (field_start) begin
      ph        = PH_START;
      radix_nxt = RAD_NONE;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      used_nxt  = '0;
      dseen_nxt = 1'b0;
    end else begin
      ph        = phase_r;
      radix_nxt = radix_r;
      acc_nxt   = acc_r;
      neg_nxt   = neg_r;
      used_nxt  = used_r;
      dseen_nxt = dseen_r;
    end
    phase_nxt = ph;
    cur       = ph;
    taken_nxt = 1'b0;
    done_nxt  = 1'b0;
    idle      = 1'b0;
    dstep     = 1'b0;
    dg        = '0;
    scaled    = '0;
    dval      = '0;

    if (cfg.field_width == '0 || cfg.field_width > NO_LIMIT_WIDTH) begin
      limit = NO_LIMIT_WIDTH;
    end else begin
      limit = cfg.field_width;
    end

    priority if (ph == PH_DONE) begin
      idle = 1'b1;
    end else if (used_nxt >= limit) begin
      done_nxt = 1'b1;
    end else begin
      if (ph == PH_START) begin
        if (char_code == CH_PLUS || char_code == CH_MINUS) begin
          neg_nxt   = (char_code == CH_MINUS);
          used_nxt  = used_nxt + 1'b1;
          taken_nxt = 1'b1;
          phase_nxt = PH_FIRST;
        end else begin
          cur = PH_FIRST;
        end
      end

      if (!taken_nxt) begin
        unique case (cur)
          PH_FIRST: begin
            // a zero may open a 0x prefix only with two characters of room left
            if ((cfg.radix_mode == MODE_AUTO || cfg.radix_mode == MODE_HEX) &&
                char_code == CH_ZERO &&
                ({1'b0, used_nxt} + (CNT_W+1)'(1)) < {1'b0, limit}) begin
              radix_nxt = (cfg.radix_mode == MODE_HEX) ? RAD_HEX : RAD_OCT;
              acc_nxt   = '0;
              dseen_nxt = 1'b1;
              used_nxt  = used_nxt + 1'b1;
              taken_nxt = 1'b1;
              phase_nxt = PH_ZERO;
            end else begin
              unique case (cfg.radix_mode)
                MODE_AUTO: radix_nxt = (char_code == CH_ZERO) ? RAD_OCT : RAD_DEC;
                MODE_OCT:  radix_nxt = RAD_OCT;
                MODE_DEC:  radix_nxt = RAD_DEC;
                MODE_HEX:  radix_nxt = RAD_HEX;
                default:   radix_nxt = RAD_DEC;
              endcase
              dstep = 1'b1;
            end
          end
          PH_ZERO: begin
            if (char_code == CH_LO_X || char_code == CH_UP_X) begin
              radix_nxt = RAD_HEX;
              acc_nxt   = '0;
              dseen_nxt = 1'b0;
              used_nxt  = used_nxt + 1'b1;
              taken_nxt = 1'b1;
              phase_nxt = PH_DIGITS;
            end else begin
              dstep = 1'b1;
            end
          end
          PH_DIGITS: dstep = 1'b1;
          default: ;
        endcase
      end

      if (dstep) begin
        dg = digit_of(char_code, radix_nxt);
        if (!dg.ok) begin
          done_nxt = 1'b1;
        end else begin
          // times 8 or 16 as a shift, times 10 as shifts and one add
          unique case (radix_nxt)
            RAD_OCT: scaled = acc_nxt << 3;
            RAD_DEC: scaled = (acc_nxt << 3) + (acc_nxt << 1);
            RAD_HEX: scaled = acc_nxt << 4;
            default: scaled = '0;
          endcase
          dval      = {{(VALUE_BITS-4){1'b0}}, dg.val};
          acc_nxt   = scaled + dval;
          dseen_nxt = 1'b1;
          used_nxt  = used_nxt + 1'b1;
          taken_nxt = 1'b1;
          phase_nxt = PH_DIGITS;
        end
      end

      if (!done_nxt && taken_nxt && used_nxt >= limit) begin
        done_nxt = 1'b1;
      end
    end

    if (done_nxt) begin
      phase_nxt = PH_DONE;
    end
    ok_nxt = done_nxt && !idle && dseen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RAD_NONE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      used_r  <= '0;
      dseen_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      used_r  <= used_nxt;
      dseen_r <= dseen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      taken_r <= taken_nxt;
      done_r  <= done_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // field state only moves with the result register, so it doubles as result payload
  assign char_taken  = taken_r;
  assign field_done  = done_r;
  assign parse_ok    = ok_r;
  assign magnitude   = acc_r;
  assign is_negative = neg_r;
  assign chars_used  = used_r;

endmodule

/* tb/ascii_integer_field_parser_tb.sv */
module ascii_integer_field_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aifp_pkg::*;

  localparam int VALUE_BITS = 64;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 110;

  localparam logic [CFG_AW-1:0] ADDR_RADIX_MODE  = {REG_RADIX_MODE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_FIELD_WIDTH = {REG_FIELD_WIDTH, 2'b00};

  typedef struct packed {
    logic                  taken;
    logic                  done;
    logic                  ok;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [CNT_W-1:0]      used;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_char_code = 8'h00;
  logic                  in_field_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_char_taken;
  logic                  out_field_done;
  logic                  out_parse_ok;
  logic [VALUE_BITS-1:0] out_magnitude;
  logic                  out_is_negative;
  logic [CNT_W-1:0]      out_chars_used;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  ascii_integer_field_parser #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_field_start  (in_field_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_taken  (out_char_taken),
    .out_field_done  (out_field_done),
    .out_parse_ok    (out_parse_ok),
    .out_magnitude   (out_magnitude),
    .out_is_negative (out_is_negative),
    .out_chars_used  (out_chars_used),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow registers and field state of the parser
  mode_t                 mode_reg = MODE_AUTO;
  logic [CNT_W-1:0]      width_reg = NO_LIMIT_WIDTH;
  phase_t                phase = PH_START;
  int                    digit_base = 0;
  logic [VALUE_BITS-1:0] acc = '0;
  logic                  minus = 1'b0;
  int                    used = 0;
  logic                  seen = 1'b0;

  parse_result_t pending_parses[$];
  int err_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  function automatic void clear_field_state();
    phase = PH_START;
    digit_base = 0;
    acc = '0;
    minus = 1'b0;
    used = 0;
    seen = 1'b0;
  endfunction

  function automatic int char_digit(input logic [7:0] c, input int base);
    int d;
    if (c >= CH_ZERO && c <= CH_NINE) d = int'(c) - int'(CH_ZERO);
    else if (c >= CH_LO_A && c <= CH_LO_Z) d = int'(c) - int'(CH_LO_A) + 10;
    else if (c >= CH_UP_A && c <= CH_UP_Z) d = int'(c) - int'(CH_UP_A) + 10;
    else return -1;
    return (d < base) ? d : -1;
  endfunction

  // Advance the field state by one character and return the expected result
  function automatic parse_result_t parse_char(input logic [7:0] c, input logic start);
    parse_result_t r;
    int lim;
    int d;
    logic taken, done, idle, dstep;
    phase_t ph;
    if (start) clear_field_state();
    lim = int'(width_reg);
    if (lim == 0 || lim > int'(NO_LIMIT_WIDTH)) lim = int'(NO_LIMIT_WIDTH);
    taken = 1'b0;
    done = 1'b0;
    idle = 1'b0;
    dstep = 1'b0;
    if (phase == PH_DONE) begin
      idle = 1'b1;
    end else if (used >= lim) begin
      done = 1'b1;
    end else begin
      ph = phase;
      if (ph == PH_START) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          minus = (c == CH_MINUS);
          used++;
          taken = 1'b1;
          phase = PH_FIRST;
        end else begin
          ph = PH_FIRST;
        end
      end
      if (!taken && ph == PH_FIRST) begin
        // a '0' may open a 0x prefix only with room for the x
        if ((mode_reg == MODE_AUTO || mode_reg == MODE_HEX) && c == CH_ZERO
            && used + 1 < lim) begin
          digit_base = (mode_reg == MODE_HEX) ? 16 : 8;
          acc = '0;
          seen = 1'b1;
          used++;
          taken = 1'b1;
          phase = PH_ZERO;
        end else begin
          case (mode_reg)
            MODE_AUTO: digit_base = (c == CH_ZERO) ? 8 : 10;
            MODE_OCT:  digit_base = 8;
            MODE_DEC:  digit_base = 10;
            default:   digit_base = 16;
          endcase
          dstep = 1'b1;
        end
      end else if (!taken && ph == PH_ZERO) begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          digit_base = 16;
          acc = '0;
          seen = 1'b0;
          used++;
          taken = 1'b1;
          phase = PH_DIGITS;
        end else begin
          dstep = 1'b1;
        end
      end else if (!taken && ph == PH_DIGITS) begin
        dstep = 1'b1;
      end
      if (dstep) begin
        d = char_digit(c, digit_base);
        if (d < 0) begin
          done = 1'b1;
        end else begin
          acc = acc * VALUE_BITS'(digit_base) + VALUE_BITS'(d);
          seen = 1'b1;
          used++;
          taken = 1'b1;
          phase = PH_DIGITS;
        end
      end
      if (!done && taken && used >= lim) done = 1'b1;
    end
    if (done) phase = PH_DONE;
    r.taken = taken;
    r.done = done && !idle;
    r.ok = done && !idle && seen;
    r.mag = acc;
    r.neg = minus;
    r.used = CNT_W'(used);
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] digit_char(input int base);
    int v;
    v = $urandom_range(0, base - 1);
    if (v < 10) return 8'(int'(CH_ZERO) + v);
    return 8'(($urandom_range(0, 1) ? int'(CH_LO_A) : int'(CH_UP_A)) + v - 10);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < 40)
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_result();
    parse_result_t e;
    if (pending_parses.size() == 0) begin
      report_mismatch("unexpected result", 64'(out_chars_used), 64'd0);
      return;
    end
    e = pending_parses.pop_front();
    if (out_char_taken !== e.taken) report_mismatch("char_taken", 64'(out_char_taken), 64'(e.taken));
    if (out_field_done !== e.done) report_mismatch("field_done", 64'(out_field_done), 64'(e.done));
    if (out_parse_ok !== e.ok) report_mismatch("parse_ok", 64'(out_parse_ok), 64'(e.ok));
    if (out_magnitude !== e.mag) report_mismatch("magnitude", out_magnitude, e.mag);
    if (out_is_negative !== e.neg) report_mismatch("is_negative", 64'(out_is_negative), 64'(e.neg));
    if (out_chars_used !== e.used) report_mismatch("chars_used", 64'(out_chars_used), 64'(e.used));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = pick_stall() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ascii_integer_field_parser] ERROR");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_field_start <= start;
    do @(posedge clk); while (in_stall);
    pending_parses.push_back(parse_char(c, start));
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit start_first);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], start_first && i == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_RADIX_MODE) mode_reg = mode_t'(data[1:0]);
    else width_reg = data[CNT_W-1:0];
  endtask

  // Reset defaults: auto radix, no width limit
  task automatic test_auto_radix();
    send_text("+12 ", 1'b1);
    send_text("-0X1f", 1'b1);
    send_char(8'h00, 1'b0);
    send_text("0xg", 1'b1);
    send_text("09", 1'b1);
    send_text("z", 1'b1);
    send_char("5", 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_fixed_radix();
    write_reg(ADDR_RADIX_MODE, CFG_DW'(MODE_OCT));
    send_text("78", 1'b1);
    write_reg(ADDR_RADIX_MODE, CFG_DW'(MODE_DEC));
    send_text("0x1", 1'b1);
    write_reg(ADDR_RADIX_MODE, CFG_DW'(MODE_HEX));
    send_text("0xFF ", 1'b1);
    send_text("-fA", 1'b1);
    send_char(8'h00, 1'b0);
    write_reg(ADDR_RADIX_MODE, CFG_DW'(MODE_AUTO));
  endtask

  task automatic test_width_limit();
    write_reg(ADDR_FIELD_WIDTH, 32'd1);
    send_text("0x", 1'b1);
    write_reg(ADDR_FIELD_WIDTH, 32'd2);
    send_text("0x", 1'b1);
    send_text("+0", 1'b1);
    write_reg(ADDR_FIELD_WIDTH, 32'd3);
    send_text("1234", 1'b1);
  endtask

  // 0 and anything above the no-limit value behave as no limit
  task automatic test_width_range();
    write_reg(ADDR_FIELD_WIDTH, 32'd0);
    send_text("99 ", 1'b1);
    write_reg(ADDR_FIELD_WIDTH, 32'h01FF_FFFF);
    send_text("77 ", 1'b1);
    write_reg(ADDR_FIELD_WIDTH, CFG_DW'(NO_LIMIT_WIDTH));
  endtask

  task automatic test_midfield_writes();
    send_text("12", 1'b1);
    write_reg(ADDR_FIELD_WIDTH, 32'd1);
    send_char("3", 1'b0);
    write_reg(ADDR_FIELD_WIDTH, CFG_DW'(NO_LIMIT_WIDTH));
    write_reg(ADDR_RADIX_MODE, CFG_DW'(MODE_DEC));
    send_text("-1", 1'b1);
    // radix stays decimal until the next field
    write_reg(ADDR_RADIX_MODE, CFG_DW'(MODE_HEX));
    send_char("f", 1'b0);
    send_text("f ", 1'b1);
    write_reg(ADDR_RADIX_MODE, CFG_DW'(MODE_AUTO));
  endtask

  task automatic send_random_field();
    int p, n, i, base;
    bit st;
    st = 1'b1;
    p = $urandom_range(0, 99);
    if (p < 12) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++)
        send_char(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 9) == 0));
      return;
    end
    p = $urandom_range(0, 3);
    if (p < 2) begin
      send_char((p == 0) ? CH_PLUS : CH_MINUS, st);
      st = 1'b0;
    end
    case (mode_reg)
      MODE_OCT: base = 8;
      MODE_DEC: base = 10;
      MODE_HEX: base = 16;
      default:  base = 10;
    endcase
    p = $urandom_range(0, 99);
    if ((mode_reg == MODE_AUTO || mode_reg == MODE_HEX) && p < 40) begin
      send_char(CH_ZERO, st);
      st = 1'b0;
      send_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X, st);
      base = 16;
    end else if (mode_reg == MODE_AUTO && p < 65) begin
      send_char(CH_ZERO, st);
      st = 1'b0;
      base = 8;
    end
    p = $urandom_range(0, 99);
    if (p < 8) n = 0;
    else if (p < 80) n = $urandom_range(1, 6);
    else n = $urandom_range(14, 24);
    for (i = 0; i < n; i++) begin
      send_char(digit_char(base), st);
      st = 1'b0;
    end
    p = $urandom_range(0, 99);
    if (p < 40) send_char(8'h20, st);
    else if (p < 55) send_char(8'h00, st);
    else if (p < 90) send_char(8'($urandom_range(0, 255)), st);
  endtask

  task automatic test_random_traffic();
    int ph, first;
    logic [CFG_DW-1:0] w;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 5)
        0:       w = CFG_DW'(NO_LIMIT_WIDTH);
        1:       w = $urandom_range(1, 3);
        2:       w = $urandom_range(4, 30);
        3:       w = $urandom_range(0, 1) ? 32'd0 : 32'h01FF_FFFF;
        default: w = $urandom_range(31, 32'h01FF_FFFF);
      endcase
      write_reg(ADDR_RADIX_MODE, (ph < 4) ? CFG_DW'(ph) : CFG_DW'($urandom_range(0, 3)));
      write_reg(ADDR_FIELD_WIDTH, w);
      no_idle = (ph == 3 || ph == 7);
      // carry the open field across the register change
      repeat ($urandom_range(0, 2)) send_char(digit_char(16), 1'b0);
      first = items_sent;
      while (items_sent - first < ITEMS_PER_PHASE) send_random_field();
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_auto_radix();
    test_fixed_radix();
    test_width_limit();
    test_width_range();
    test_midfield_writes();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("[ascii_integer_field_parser] OK");
    end else begin
      $display("[ascii_integer_field_parser] ERROR");
    end
    $finish;
  end

endmodule

/* ascii_integer_field_parser.f */
rtl/aifp_pkg.sv
rtl/aifp_regs.sv
rtl/aifp_core.sv
rtl/ascii_integer_field_parser.sv
tb/ascii_integer_field_parser_tb.sv
